/* src/vlq_pkg.sv */
package vlq_pkg;

  // field kinds selected by op at field start
  localparam logic [1:0] KIND_FIXED  = 2'd0;
  localparam logic [1:0] KIND_VARINT = 2'd1;
  localparam logic [1:0] KIND_ARRAY  = 2'd2;
  localparam logic [1:0] KIND_STRING = 2'd3;

  // result kinds
  localparam logic [1:0] RES_NUMBER  = 2'd0;
  localparam logic [1:0] RES_LENGTH  = 2'd1;
  localparam logic [1:0] RES_PAYLOAD = 2'd2;

  // status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_STRING = 1'b1;

  // fixed-number layout
  localparam int unsigned FIXED_BYTES_DEFAULT = 8;
  localparam int unsigned FIXED_CNT_W         = 3;

  // varint byte fields
  localparam logic [7:0] VARINT_MORE = 8'h80;
  localparam logic [7:0] VARINT_BITS = 8'h7f;
  localparam logic [7:0] STRING_TERM = 8'h00;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] value;
    logic        last;
    logic        status;
  } result_t;

endpackage

/* src/vlq_core.sv */
module vlq_core #(
  parameter int unsigned FIXED_BYTES = vlq_pkg::FIXED_BYTES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  vlq_pkg::item_t  item,
  output logic            res_fire,
  output vlq_pkg::result_t res
);
  import vlq_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FIXED   = 2'd1,
    PH_VARINT  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  localparam logic [FIXED_CNT_W:0] FIXED_LAST = (FIXED_CNT_W + 1)'(FIXED_BYTES);

  phase_t                 phase, phase_next;
  logic [1:0]             field_kind, field_kind_next;
  logic [63:0]            accumulator, accumulator_next;
  logic [FIXED_CNT_W-1:0] fixed_byte_count, fixed_byte_count_next;
  logic [63:0]            payload_remaining, payload_remaining_next;

  logic [1:0]             kind_cur;
  logic [63:0]            acc_base;
  logic [FIXED_CNT_W-1:0] cnt_base;
  logic [FIXED_CNT_W:0]   cnt_inc;
  logic [63:0]            fixed_acc;
  logic [63:0]            varint_acc;
  logic [7:0]             b;
  logic                   use_fixed;
  logic                   use_varint;

  assign b = item.data_byte;

  // field start clears the working state and latches the kind
  always_comb begin
    if (phase == PH_IDLE) begin
      kind_cur = item.op;
      acc_base = '0;
      cnt_base = '0;
    end else begin
      kind_cur = field_kind;
      acc_base = accumulator;
      cnt_base = fixed_byte_count;
    end
  end

  assign use_fixed  = (phase == PH_FIXED) || (phase == PH_IDLE && item.op == KIND_FIXED);
  assign use_varint = (phase == PH_VARINT) || (phase == PH_IDLE && item.op != KIND_FIXED);

  // byte placement for the little-endian number and group shift for the varint
  assign fixed_acc  = acc_base | ({56'd0, b} << {cnt_base, 3'b000});
  assign varint_acc = {acc_base[56:0], b[6:0] & VARINT_BITS[6:0]};
  assign cnt_inc    = {1'b0, cnt_base} + {{FIXED_CNT_W{1'b0}}, 1'b1};

  // next state and result
  always_comb begin
    phase_next             = phase;
    field_kind_next        = kind_cur;
    accumulator_next       = accumulator;
    fixed_byte_count_next  = fixed_byte_count;
    payload_remaining_next = payload_remaining;
    res_fire               = 1'b0;
    res.result_kind        = RES_NUMBER;
    res.value              = '0;
    res.last               = 1'b0;
    res.status             = STATUS_OK;

    if (phase == PH_IDLE) begin
      payload_remaining_next = '0;
    end

    if (use_fixed) begin
      accumulator_next = fixed_acc;
      if (cnt_inc >= FIXED_LAST) begin
        phase_next            = PH_IDLE;
        fixed_byte_count_next = '0;
        res_fire              = 1'b1;
        res.result_kind       = RES_NUMBER;
        res.value             = fixed_acc;
        res.last              = 1'b1;
      end else begin
        phase_next            = PH_FIXED;
        fixed_byte_count_next = cnt_inc[FIXED_CNT_W-1:0];
      end
    end else if (use_varint) begin
      accumulator_next      = varint_acc;
      fixed_byte_count_next = cnt_base;
      if ((b & VARINT_MORE) != 8'd0) begin
        phase_next = PH_VARINT;
      end else if (kind_cur == KIND_VARINT) begin
        phase_next      = PH_IDLE;
        res_fire        = 1'b1;
        res.result_kind = RES_NUMBER;
        res.value       = varint_acc;
        res.last        = 1'b1;
      end else if (varint_acc == 64'd0) begin
        // empty array or string
        phase_next      = PH_IDLE;
        res_fire        = 1'b1;
        res.result_kind = RES_LENGTH;
        res.value       = '0;
        res.last        = 1'b1;
        res.status      = (kind_cur == KIND_STRING) ? STATUS_BAD_STRING : STATUS_OK;
      end else begin
        phase_next             = PH_PAYLOAD;
        payload_remaining_next = varint_acc;
        res_fire               = 1'b1;
        res.result_kind        = RES_LENGTH;
        res.value              = varint_acc;
      end
    end else begin
      // payload byte
      payload_remaining_next = payload_remaining - 64'd1;
      res_fire               = 1'b1;
      res.result_kind        = RES_PAYLOAD;
      res.value              = {56'd0, b};
      if (payload_remaining == 64'd1) begin
        phase_next = PH_IDLE;
        res.last   = 1'b1;
        res.status = (field_kind == KIND_STRING && b != STRING_TERM)
                     ? STATUS_BAD_STRING : STATUS_OK;
      end
    end
  end

  // field state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      field_kind        <= KIND_FIXED;
      accumulator       <= '0;
      fixed_byte_count  <= '0;
      payload_remaining <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      field_kind        <= field_kind_next;
      accumulator       <= accumulator_next;
      fixed_byte_count  <= fixed_byte_count_next;
      payload_remaining <= payload_remaining_next;
    end
  end

endmodule

/* src/vlq_out_buf.sv */
module vlq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vlq_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output vlq_pkg::result_t out_data
);
  import vlq_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    load_out;

  assign full     = skid_valid;
  assign load_out = !out_valid || !out_stall;

  // output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* src/vlq_field_decoder.sv */
// Field decoder for a byte stream of fixed numbers, varints, byte arrays and strings.
// Input channel: data (op and data_byte) with data_valid / data_stall. One byte
// is taken per transfer; op is read only on the first byte of a field.
// Output channel: result (result_kind, value, last, status) with result_valid /
// result_stall. A fixed or varint field gives one number result on its last
// byte; an array or string gives a length result, then one result per payload
// byte. status flags a string that is empty or not zero-terminated.
// Throughput: one byte per cycle while data_stall is low. Each byte passes through one
// combinational step (64-bit byte shift or 7-bit group shift, length decrement) into the
// field state registers and the result register.
// A result is held in the result register before it appears on the port.
// When the receiver stalls, the result register holds and a skid stage takes
// one more result; data_stall rises only once that skid stage is full, so
// bytes that give no result and one result-bearing byte still pass.
// Reset (rst, synchronous) returns the decoder to the start of a field and
// empties the result register and skid stage.
module vlq_field_decoder #(
  parameter int unsigned FIXED_BYTES = vlq_pkg::FIXED_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             data_valid,
  output logic             data_stall,
  input  vlq_pkg::item_t   data,
  output logic             result_valid,
  input  logic             result_stall,
  output vlq_pkg::result_t result
);
  import vlq_pkg::*;

  logic    accept;
  logic    res_fire;
  result_t res;
  logic    buf_full;

  // input transfer
  assign data_stall = buf_full;
  assign accept     = data_valid && !buf_full;

  vlq_core #(
    .FIXED_BYTES(FIXED_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (data),
    .res_fire(res_fire),
    .res     (res)
  );

  vlq_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && res_fire),
    .push_data(res),
    .full     (buf_full),
    .out_valid(result_valid),
    .out_stall(result_stall),
    .out_data (result)
  );

endmodule

/* test/vlq_field_decoder_tb.sv */
module vlq_field_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vlq_pkg::*;

  localparam int unsigned FIXED_BYTES = FIXED_BYTES_DEFAULT;
  localparam int PHASE_BYTES = 290;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam longint CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {ST_IDLE, ST_FIXED, ST_VARINT, ST_PAYLOAD} dec_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic data_valid = 1'b0;
  logic data_stall;
  item_t data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  item_t pending_bytes[$];
  result_t expected_results[$];
  int sender_idle_pct = 0;
  int stall_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;
  int error_count = 0;
  int bytes_sent = 0;
  int bytes_queued = 0;
  int results_by_kind[4] = '{0, 0, 0, 0};
  int bad_strings = 0;
  longint cycle_count = 0;

  // decoder state mirrored by the predictor
  dec_state_t dec_state = ST_IDLE;
  logic [1:0] dec_kind = KIND_FIXED;
  logic [63:0] dec_acc = '0;
  logic [2:0] dec_fixed_cnt = '0;
  logic [63:0] dec_remaining = '0;

  vlq_field_decoder DUT (
    .clk(clk),
    .rst(rst),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data(data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decode one byte and queue the result it gives, if any
  task automatic decode_byte(input item_t it);
    result_t r;
    logic emit;
    emit = 1'b0;
    r = '0;
    // a field starts on the first byte taken while idle
    if (dec_state == ST_IDLE) begin
      dec_kind = it.op;
      dec_acc = '0;
      dec_fixed_cnt = '0;
      dec_remaining = '0;
      dec_state = (it.op == KIND_FIXED) ? ST_FIXED : ST_VARINT;
    end
    case (dec_state)
      ST_FIXED: begin
        dec_acc = dec_acc | (64'(it.data_byte) << (8 * dec_fixed_cnt));
        if (int'(dec_fixed_cnt) + 1 >= FIXED_BYTES) begin
          r = '{RES_NUMBER, dec_acc, 1'b1, STATUS_OK};
          emit = 1'b1;
          dec_state = ST_IDLE;
          dec_fixed_cnt = '0;
        end else begin
          dec_fixed_cnt = dec_fixed_cnt + 3'd1;
        end
      end
      ST_VARINT: begin
        dec_acc = (dec_acc << 7) | 64'(it.data_byte & VARINT_BITS);
        if ((it.data_byte & VARINT_MORE) == 8'h00) begin
          emit = 1'b1;
          if (dec_kind == KIND_VARINT) begin
            r = '{RES_NUMBER, dec_acc, 1'b1, STATUS_OK};
            dec_state = ST_IDLE;
          end else if (dec_acc == '0) begin
            // empty array is fine, empty string is flagged
            r = '{RES_LENGTH, 64'd0, 1'b1,
                  (dec_kind == KIND_STRING) ? STATUS_BAD_STRING : STATUS_OK};
            dec_state = ST_IDLE;
          end else begin
            dec_remaining = dec_acc;
            r = '{RES_LENGTH, dec_acc, 1'b0, STATUS_OK};
            dec_state = ST_PAYLOAD;
          end
        end
      end
      default: begin
        dec_remaining = dec_remaining - 64'd1;
        emit = 1'b1;
        if (dec_remaining == '0) begin
          r = '{RES_PAYLOAD, 64'(it.data_byte), 1'b1,
                (dec_kind == KIND_STRING && it.data_byte != STRING_TERM) ?
                STATUS_BAD_STRING : STATUS_OK};
          dec_state = ST_IDLE;
        end else begin
          r = '{RES_PAYLOAD, 64'(it.data_byte), 1'b0, STATUS_OK};
        end
      end
    endcase
    if (emit) expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: kind %0d value %0h", got.result_kind, got.value);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      check_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      check_field("value", want.value, got.value);
      check_field("last", 64'(want.last), 64'(got.last));
      check_field("status", 64'(want.status), 64'(got.status));
      results_by_kind[want.result_kind]++;
      if (want.status == STATUS_BAD_STRING) bad_strings++;
    end
  endtask

  // driver: offers queued bytes, holds each until the transfer happens
  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else if (!data_valid || !data_stall) begin
      if (data_valid) begin
        decode_byte(data);
        bytes_sent++;
      end
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        data <= pending_bytes.pop_front();
        data_valid <= 1'b1;
      end else begin
        data_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result transfer, stalls at random or during a hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // long receiver hold-off counter
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("vlq_field_decoder test failed");
      $finish;
    end
  end

  task automatic queue_byte(input logic [1:0] op, input logic [7:0] b);
    item_t it;
    it.op = op;
    it.data_byte = b;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  function automatic int groups_for(input logic [95:0] v);
    int n;
    n = 1;
    while ((v >> (7 * n)) != 0) n++;
    return n;
  endfunction

  // most significant group first; op is random on every byte after the first
  task automatic queue_varint(input logic [1:0] kind, input logic [95:0] v, input int groups);
    int i;
    logic [7:0] b;
    for (i = groups - 1; i >= 0; i--) begin
      b = 8'(v >> (7 * i)) & VARINT_BITS;
      if (i != 0) b = b | VARINT_MORE;
      queue_byte((i == groups - 1) ? kind : 2'($urandom), b);
    end
  endtask

  task automatic queue_fixed(input logic [63:0] v);
    int i;
    for (i = 0; i < FIXED_BYTES; i++)
      queue_byte((i == 0) ? KIND_FIXED : 2'($urandom), v[8 * i +: 8]);
  endtask

  // array or string with random payload, strings mostly zero-terminated
  task automatic queue_blob(input logic [1:0] kind);
    int len;
    int i;
    logic term;
    logic [7:0] b;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    term = (kind == KIND_STRING) && ($urandom_range(0, 3) != 0);
    queue_varint(kind, 96'(len),
                 groups_for(96'(len)) + (($urandom_range(0, 7) == 0) ? 1 : 0));
    for (i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (term && i == len - 1) b = STRING_TERM;
      queue_byte(2'($urandom), b);
    end
  endtask

  task automatic queue_random_field();
    int sel;
    int nbits;
    logic [95:0] v;
    sel = $urandom_range(0, 99);
    v = {$urandom, $urandom, $urandom};
    if (sel < 8) begin
      // stray byte: starts or continues whatever field is open
      queue_byte(2'($urandom), 8'($urandom));
    end else if (sel < 28) begin
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = '1;
        default: ;
      endcase
      queue_fixed(v[63:0]);
    end else if (sel < 50) begin
      if ($urandom_range(0, 4) == 0) begin
        // longer than 64 bits, upper groups fall off
        queue_varint(KIND_VARINT, v, $urandom_range(10, 13));
      end else begin
        nbits = $urandom_range(0, 64);
        v = v & ((96'd1 << nbits) - 96'd1);
        queue_varint(KIND_VARINT, v,
                     groups_for(v) + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0));
      end
    end else begin
      queue_blob((sel < 75) ? KIND_ARRAY : KIND_STRING);
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || data_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input logic hold);
    int target;
    @(negedge clk);
    sender_idle_pct = idle_pct;
    stall_pct = stall;
    target = bytes_queued + PHASE_BYTES;
    while (bytes_queued < target) queue_random_field();
    if (hold) begin
      hold_start = 1'b1;
      @(negedge clk);
      hold_start = 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed fields
    @(negedge clk);
    queue_fixed('1);
    queue_byte(KIND_VARINT, 8'h00);
    queue_byte(KIND_VARINT, 8'h7f);
    queue_byte(KIND_VARINT, 8'h81);
    queue_byte(KIND_STRING, 8'h00);
    queue_byte(KIND_ARRAY, 8'h00);
    queue_byte(KIND_STRING, 8'h00);
    queue_byte(KIND_ARRAY, 8'h01);
    queue_byte(KIND_FIXED, 8'hff);
    queue_byte(KIND_STRING, 8'h02);
    queue_byte(KIND_VARINT, 8'h41);
    queue_byte(KIND_ARRAY, STRING_TERM);
    queue_byte(KIND_STRING, 8'h01);
    queue_byte(KIND_STRING, 8'h41);
    wait_drained();

    // random fields under different flow control
    run_phase(0, 0, 1'b0);
    run_phase(66, 0, 1'b0);
    run_phase(0, 66, 1'b0);
    run_phase(38, 38, 1'b0);
    run_phase(0, 0, 1'b1);

    // array whose length cannot be reached, only its first bytes go in
    @(negedge clk);
    queue_varint(KIND_ARRAY, {32'h0, $urandom, $urandom} | (96'd1 << 63), 10);
    repeat (6) queue_byte(2'($urandom), 8'($urandom));
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d bytes; checked %0d numbers, %0d lengths, %0d payload bytes",
             bytes_sent, results_by_kind[RES_NUMBER], results_by_kind[RES_LENGTH],
             results_by_kind[RES_PAYLOAD]);
    $display("%0d bad strings flagged, %0d errors", bad_strings, error_count);
    if (error_count == 0) begin
      $display("vlq_field_decoder test passed");
    end else begin
      $display("vlq_field_decoder test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/vlq_pkg.sv
src/vlq_core.sv
src/vlq_out_buf.sv
src/vlq_field_decoder.sv
test/vlq_field_decoder_tb.sv
